/* hdl/assert_macros.svh */
// Assertion macros shared by the console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ASSERT_IMPL(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_CHK(label, clock, reset, prop, msg)
`define ASSERT_IMPL(label, clock, reset, ante, cons, msg)
`endif

`endif

/* hdl/tcc_pkg.sv */
// Shared types, codes and name tables of the text console.
package tcc_pkg;

  localparam int ADDR_W = 11;

  localparam logic [1:0] ACT_MARKUP = 2'd0;
  localparam logic [1:0] ACT_RAW    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [7:0] DEFAULT_COLOR_RESET = 8'h0F;

  localparam int NAME_COUNT = 8;
  localparam int NAME_SLOTS = 8;

  localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_SLOTS] = '{
    '{"b", "l", "a", "c", "k", 8'h00, 8'h00, 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00, 8'h00, 8'h00},
    '{"c", "y", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "a", "g", "e", "n", "t", "a", 8'h00},
    '{"y", "e", "l", "l", "o", "w", 8'h00, 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
    3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd7, 3'd6, 3'd5
  };
  localparam logic [7:0] NAME_CODE [NAME_COUNT] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h0E, 8'h0F
  };

  // Command word passed from the tag parser to the cursor unit.
  typedef struct packed {
    logic       is_clear;
    logic [7:0] code;
    logic [7:0] attr;
  } cmd_t;

endpackage

/* hdl/tcc_if.sv */
// Input and output channel interfaces of the text console.
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;
  logic       last_of_string;

  modport source (output valid, action, char_code, last_of_string, input ready);
  modport sink (input valid, action, char_code, last_of_string, output ready);
endinterface

interface tcc_out_if;
  logic        valid;
  logic        ready;
  logic        cell_write;
  logic [10:0] cell_address;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        scroll_up;
  logic        clear_all;
  logic [7:0]  fill_attr;
  logic [10:0] cursor_pos;

  modport source (output valid, cell_write, cell_address, cell_char, cell_attr,
                  scroll_up, clear_all, fill_attr, cursor_pos, input ready);
  modport sink (input valid, cell_write, cell_address, cell_char, cell_attr,
                scroll_up, clear_all, fill_attr, cursor_pos, output ready);
endinterface

/* hdl/text_console_with_color_tags.sv */
// Top level of the text console with color tags.
//
//  channel  dir  word
//  in_ch    in   action, char_code, last_of_string
//  out_ch   out  cell write, scroll/clear request, cursor position
//  cfg      in   default_color (write enable + data)
//
// One character is accepted per cycle while the command queue is not full; a result
// word passes through the queue, then the output register.
// Tag characters produce no word. A two-word command queue lets the tag
// parser keep accepting while the output side is stalled; input ready drops
// only when that queue is full. Reset is synchronous.
module text_console_with_color_tags #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAG_CHARS = 15
) (
  input  logic       clk,
  input  logic       rst,
  tcc_in_if.sink     in_ch,
  tcc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tcc_pkg::*;

  logic q_full, q_valid, push, pop;
  cmd_t push_data, q_head;

  tcc_front #(.TAG_CHARS(TAG_CHARS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  tcc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* hdl/tcc_front.sv */
// Front end: accepts characters, parses color tags, issues commands.
module tcc_front #(
  parameter int TAG_CHARS = 15
) (
  input  logic          clk,
  input  logic          rst,
  tcc_in_if.sink        in_ch,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          q_full,
  output logic          push,
  output tcc_pkg::cmd_t push_data
);
  import tcc_pkg::*;

  localparam int LEN_W = $clog2(TAG_CHARS + 1);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_OPEN = 4'b0010,
    PH_NAME = 4'b0100,
    PH_FULL = 4'b1000
  } phase_t;

  phase_t                phase, phase_next;
  logic                  closing, closing_next;
  logic [LEN_W-1:0]      len, len_next;
  logic [NAME_COUNT-1:0] ok, ok_next;
  logic [7:0]            active, active_next;
  logic [7:0]            default_color;
  logic                  do_close;
  logic                  idle_path;
  logic [7:0]            c;
  logic                  last;

  assign in_ch.ready = !q_full;
  assign c    = in_ch.char_code;
  assign last = in_ch.last_of_string;

  always_comb begin
    phase_next   = phase;
    closing_next = closing;
    len_next     = len;
    ok_next      = ok;
    active_next  = active;
    do_close     = 1'b0;
    idle_path    = 1'b0;
    push         = 1'b0;
    push_data    = '0;
    if (in_ch.valid && in_ch.ready) begin
      case (in_ch.action)
        ACT_MARKUP: begin
          idle_path = (phase == PH_IDLE) || ((phase == PH_FULL) && (c != CH_GT));
          if (phase == PH_FULL) begin
            phase_next = PH_IDLE;
          end
          if (idle_path) begin
            if (c != CH_LT) begin
              push      = 1'b1;
              push_data = '{is_clear: 1'b0, code: c, attr: active};
            end else begin
              closing_next = 1'b0;
              len_next     = '0;
              ok_next      = '1;
              phase_next   = last ? PH_IDLE : PH_OPEN;
            end
          end else if (phase == PH_FULL) begin
            phase_next = PH_IDLE;
          end else if ((phase == PH_OPEN) && (c == CH_SLASH)) begin
            closing_next = 1'b1;
            if (last) begin
              do_close   = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_NAME;
            end
          end else if (c == CH_GT) begin
            do_close   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            if (len < LEN_W'(TAG_CHARS)) begin
              for (int k = 0; k < NAME_COUNT; k++) begin
                ok_next[k] = ok[k] && (len < LEN_W'(NAME_LEN[k])) &&
                             (NAME_TEXT[k][len[2:0]] == c);
              end
              len_next = len + 1'b1;
            end
            if (last) begin
              do_close   = 1'b1;
              phase_next = PH_IDLE;
            end else if (len_next >= LEN_W'(TAG_CHARS)) begin
              do_close   = 1'b1;
              phase_next = PH_FULL;
            end else begin
              phase_next = PH_NAME;
            end
          end
        end
        ACT_RAW: begin
          push      = 1'b1;
          push_data = '{is_clear: 1'b0, code: c, attr: active};
        end
        ACT_CLEAR: begin
          push      = 1'b1;
          push_data = '{is_clear: 1'b1, code: 8'h00, attr: active};
        end
        default: begin
        end
      endcase
    end
    if (do_close) begin
      if (closing_next) begin
        active_next = default_color;
      end else begin
        for (int k = 0; k < NAME_COUNT; k++) begin
          if (ok_next[k] && (len_next == LEN_W'(NAME_LEN[k]))) begin
            active_next = NAME_CODE[k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      closing       <= 1'b0;
      len           <= '0;
      ok            <= '1;
      active        <= DEFAULT_COLOR_RESET;
      default_color <= DEFAULT_COLOR_RESET;
    end else begin
      phase   <= phase_next;
      closing <= closing_next;
      len     <= len_next;
      ok      <= ok_next;
      active  <= active_next;
      if (cfg_we) begin
        default_color <= cfg_wdata;
      end
    end
  end

endmodule

/* hdl/tcc_queue.sv */
// Two-word command queue between tag parser and cursor unit.
`include "assert_macros.svh"
module tcc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcc_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output tcc_pkg::cmd_t head
);
  import tcc_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CHK(a_q_count, clk, rst, count <= CNT_W'(DEPTH), "queue count overflow")
  `ASSERT_IMPL(a_q_push, clk, rst, push, !full, "push into full queue")
  `ASSERT_IMPL(a_q_pop, clk, rst, pop, not_empty, "pop from empty queue")

endmodule

/* hdl/tcc_back.sv */
// Back end: cursor movement, scroll and clear, output word register.
`include "assert_macros.svh"
module tcc_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tcc_pkg::cmd_t q_data,
  output logic          pop,
  tcc_out_if.source     out_ch
);
  import tcc_pkg::*;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COLX_W = $clog2(COLUMNS + 1);
  localparam int ROWX_W = $clog2(ROWS + 1);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [COLX_W-1:0] ncol;
  logic [ROWX_W-1:0] nrow;
  logic              wr, scr;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        ch;

  function automatic logic [ADDR_W-1:0] linear(input logic [ROWX_W-1:0] r,
                                               input logic [COLX_W-1:0] c);
    return ADDR_W'(32'(r) * 32'(COLUMNS) + 32'(c));
  endfunction

  assign pop = q_valid && (!out_ch.valid || out_ch.ready);

  always_comb begin
    ncol = COLX_W'(col);
    nrow = ROWX_W'(row);
    wr   = 1'b0;
    addr = '0;
    ch   = 8'h00;
    scr  = 1'b0;
    case (q_data.code)
      CH_NL: begin
        ncol = '0;
        nrow = ROWX_W'(row) + 1'b1;
      end
      CH_BS: begin
        if (col != '0) begin
          ncol = COLX_W'(col) - 1'b1;
        end else if (row != '0) begin
          nrow = ROWX_W'(row) - 1'b1;
          ncol = COLX_W'(COLUMNS - 1);
        end
        wr   = 1'b1;
        addr = linear(nrow, ncol);
        ch   = CH_SPACE;
      end
      default: begin
        wr   = 1'b1;
        addr = linear(ROWX_W'(row), COLX_W'(col));
        ch   = q_data.code;
        ncol = COLX_W'(col) + 1'b1;
        if (ncol >= COLX_W'(COLUMNS)) begin
          ncol = '0;
          nrow = ROWX_W'(row) + 1'b1;
        end
      end
    endcase
    if (nrow >= ROWX_W'(ROWS)) begin
      scr  = 1'b1;
      nrow = ROWX_W'(ROWS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      col          <= '0;
      row          <= '0;
    end else begin
      if (pop) begin
        out_ch.valid <= 1'b1;
        if (q_data.is_clear) begin
          col <= '0;
          row <= '0;
        end else begin
          col <= ncol[COL_W-1:0];
          row <= nrow[ROW_W-1:0];
        end
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_data.is_clear) begin
        out_ch.cell_write   <= 1'b0;
        out_ch.cell_address <= '0;
        out_ch.cell_char    <= 8'h00;
        out_ch.cell_attr    <= 8'h00;
        out_ch.scroll_up    <= 1'b0;
        out_ch.clear_all    <= 1'b1;
        out_ch.fill_attr    <= q_data.attr;
        out_ch.cursor_pos   <= '0;
      end else begin
        out_ch.cell_write   <= wr;
        out_ch.cell_address <= addr;
        out_ch.cell_char    <= ch;
        out_ch.cell_attr    <= wr ? q_data.attr : 8'h00;
        out_ch.scroll_up    <= scr;
        out_ch.clear_all    <= 1'b0;
        out_ch.fill_attr    <= scr ? q_data.attr : 8'h00;
        out_ch.cursor_pos   <= linear(nrow, ncol);
      end
    end
  end

  `ASSERT_CHK(a_col_range, clk, rst, COLX_W'(col) < COLX_W'(COLUMNS), "column out of range")
  `ASSERT_CHK(a_row_range, clk, rst, ROWX_W'(row) < ROWX_W'(ROWS), "row out of range")
  `ASSERT_IMPL(a_clear_word, clk, rst, out_ch.valid && out_ch.clear_all,
               !out_ch.cell_write && !out_ch.scroll_up, "clear word carries a cell write")

endmodule

/* tb/sv/text_console_with_color_tags_test.sv */
// Self-checking testbench of the text console: tag parsing, cursor moves, scroll and clear.
module text_console_with_color_tags_test;
  import tcc_pkg::*;

  localparam int COLS        = 80;
  localparam int ROWS_N      = 25;
  localparam int TAG_MAX     = 15;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef enum logic [1:0] {TAG_OUT, TAG_OPEN, TAG_NAME, TAG_FULL} tag_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] code;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic        wr;
    logic [10:0] addr;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic        scroll;
    logic        clr;
    logic [7:0]  fill;
    logic [10:0] cursor;
  } screen_op_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  tcc_in_if  in_ch ();
  tcc_out_if out_ch ();

  text_console_with_color_tags dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  char_word_t chars_to_send [$];
  screen_op_t screen_ops_due [$];
  int         send_idle_pct;
  int         recv_idle_pct;
  int         chars_queued;
  int         bad_words;
  int         cycles;
  bit         in_took;

  // console state as predicted
  logic [6:0] con_col;
  logic [4:0] con_row;
  logic [7:0] color_now;
  logic [7:0] color_dflt;
  tag_phase_t tag_phase;
  logic       tag_close;
  logic [7:0] tag_buf [TAG_MAX];
  logic [3:0] tag_len;

  string      color_names [8] = '{"black", "blue", "green", "cyan", "red", "magenta",
                                  "yellow", "white"};
  logic [7:0] color_codes [8] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h0E, 8'h0F};

  function automatic logic [10:0] cell_of(int r, int c);
    return 11'(r * COLS + c);
  endfunction

  function automatic void apply_tag();
    bit hit;
    if (tag_close) begin
      color_now = color_dflt;
      return;
    end
    for (int k = 0; k < 8; k++) begin
      if (color_names[k].len() == int'(tag_len)) begin
        hit = 1;
        for (int i = 0; i < color_names[k].len(); i++)
          if (tag_buf[i] != color_names[k][i]) hit = 0;
        if (hit) begin
          color_now = color_codes[k];
          return;
        end
      end
    end
  endfunction

  function automatic screen_op_t print_char(logic [7:0] c);
    screen_op_t op;
    op = '0;
    if (c == CH_NL) begin
      con_col = 0;
      con_row = con_row + 5'd1;
    end else if (c == CH_BS) begin
      if (con_col > 0) begin
        con_col = con_col - 7'd1;
      end else if (con_row > 0) begin
        con_row = con_row - 5'd1;
        con_col = 7'(COLS - 1);
      end
      op.wr   = 1;
      op.addr = cell_of(con_row, con_col);
      op.ch   = CH_SPACE;
      op.attr = color_now;
    end else begin
      op.wr   = 1;
      op.addr = cell_of(con_row, con_col);
      op.ch   = c;
      op.attr = color_now;
      con_col = con_col + 7'd1;
      if (con_col >= COLS) begin
        con_col = 0;
        con_row = con_row + 5'd1;
      end
    end
    if (con_row >= ROWS_N) begin
      op.scroll = 1;
      op.fill   = color_now;
      con_row   = 5'(ROWS_N - 1);
    end
    op.cursor = cell_of(con_row, con_col);
    return op;
  endfunction

  task automatic open_or_print(logic [7:0] c, logic last);
    if (c != CH_LT) begin
      screen_ops_due.push_back(print_char(c));
      return;
    end
    tag_close = 0;
    tag_len   = 0;
    if (last) begin
      apply_tag();
      tag_phase = TAG_OUT;
    end else begin
      tag_phase = TAG_OPEN;
    end
  endtask

  task automatic markup_step(logic [7:0] c, logic last);
    if (tag_phase == TAG_OUT) begin
      open_or_print(c, last);
      return;
    end
    if (tag_phase == TAG_FULL) begin
      tag_phase = TAG_OUT;
      if (c != CH_GT) open_or_print(c, last);
      return;
    end
    if (tag_phase == TAG_OPEN && c == CH_SLASH) begin
      tag_close = 1;
      if (last) begin
        apply_tag();
        tag_phase = TAG_OUT;
      end else begin
        tag_phase = TAG_NAME;
      end
      return;
    end
    if (c == CH_GT) begin
      apply_tag();
      tag_phase = TAG_OUT;
      return;
    end
    if (tag_len < TAG_MAX) begin
      tag_buf[tag_len] = c;
      tag_len = tag_len + 4'd1;
    end
    if (last) begin
      apply_tag();
      tag_phase = TAG_OUT;
    end else if (tag_len >= TAG_MAX) begin
      apply_tag();
      tag_phase = TAG_FULL;
    end else begin
      tag_phase = TAG_NAME;
    end
  endtask

  task automatic console_step(char_word_t w);
    screen_op_t op;
    case (w.action)
      ACT_MARKUP: markup_step(w.code, w.last);
      ACT_RAW: screen_ops_due.push_back(print_char(w.code));
      ACT_CLEAR: begin
        op      = '0;
        op.clr  = 1;
        op.fill = color_now;
        con_col = 0;
        con_row = 0;
        screen_ops_due.push_back(op);
      end
      default: ;
    endcase
  endtask

  task automatic push(logic [1:0] a, logic [7:0] c, logic l);
    chars_to_send.push_back({a, c, l});
    if (a != ACT_NONE) chars_queued++;
  endtask

  // markup string, sometimes ended early by last_of_string
  task automatic send_markup(input logic [7:0] s [$]);
    int stop;
    bit end_mark;
    stop     = s.size() - 1;
    end_mark = ($urandom_range(99) < 15);
    if ($urandom_range(9) == 0) begin
      stop     = $urandom_range(s.size() - 1);
      end_mark = 1;
    end
    for (int i = 0; i <= stop; i++)
      push(ACT_MARKUP, s[i], (i == stop) && end_mark);
  endtask

  task automatic add_segment();
    int         kind;
    int         n;
    string      nm;
    logic [7:0] seq [$];
    kind = $urandom_range(99);
    seq  = {};
    if (kind < 30) begin
      n = $urandom_range(1, 6);
      repeat (n) seq.push_back(8'($urandom_range(32, 126)));
      send_markup(seq);
    end else if (kind < 45) begin
      nm = color_names[$urandom_range(7)];
      seq.push_back(CH_LT);
      for (int i = 0; i < nm.len(); i++) seq.push_back(nm[i]);
      seq.push_back(CH_GT);
      send_markup(seq);
    end else if (kind < 53) begin
      seq.push_back(CH_LT);
      seq.push_back(CH_SLASH);
      n = $urandom_range(4);
      repeat (n) seq.push_back(8'($urandom_range(97, 122)));
      seq.push_back(CH_GT);
      send_markup(seq);
    end else if (kind < 61) begin
      seq.push_back(CH_LT);
      n = $urandom_range(1, 6);
      repeat (n) seq.push_back(8'($urandom_range(97, 122)));
      seq.push_back(CH_GT);
      send_markup(seq);
    end else if (kind < 66) begin
      seq.push_back(CH_LT);
      if ($urandom_range(1) == 0) seq.push_back(CH_SLASH);
      n = $urandom_range(15, 16);
      repeat (n) seq.push_back(8'($urandom_range(97, 122)));
      if ($urandom_range(1) == 0) seq.push_back(CH_GT);
      send_markup(seq);
    end else if (kind < 78) begin
      push($urandom_range(1) ? ACT_RAW : ACT_MARKUP, CH_NL, 1'($urandom_range(1)));
    end else if (kind < 85) begin
      push($urandom_range(1) ? ACT_RAW : ACT_MARKUP, CH_BS, 1'($urandom_range(1)));
    end else if (kind < 92) begin
      n = $urandom_range(1, 4);
      repeat (n) push(ACT_RAW, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (kind < 94) begin
      push(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else begin
      push(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  task automatic fill_random(int count);
    int target;
    target = chars_queued + count;
    while (chars_queued < target) add_segment();
  endtask

  task automatic settle();
    while (chars_to_send.size() != 0 || screen_ops_due.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_default(logic [7:0] v);
    @(negedge clk);
    cfg_we     <= 1;
    cfg_wdata  <= v;
    color_dflt  = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver and ready generator
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid  <= 0;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_ch.valid || in_took) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid          <= 1;
          in_ch.action         <= chars_to_send[0].action;
          in_ch.char_code      <= chars_to_send[0].code;
          in_ch.last_of_string <= chars_to_send[0].last;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // monitor: accepts input words into the predictor, checks output words
  always @(posedge clk) begin
    screen_op_t got;
    screen_op_t want;
    in_took = 0;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.cell_write, out_ch.cell_address, out_ch.cell_char, out_ch.cell_attr,
               out_ch.scroll_up, out_ch.clear_all, out_ch.fill_attr, out_ch.cursor_pos};
        if (screen_ops_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) $display("unexpected word: %h", got);
        end else begin
          want = screen_ops_due.pop_front();
          if (got.wr !== want.wr || got.addr !== want.addr || got.ch !== want.ch ||
              got.attr !== want.attr || got.scroll !== want.scroll ||
              got.clr !== want.clr || got.fill !== want.fill ||
              got.cursor !== want.cursor) begin
            bad_words++;
            if (bad_words <= 10)
              $display({"word mismatch: exp wr=%0d addr=%0d ch=%h attr=%h scr=%0d clr=%0d",
                        " fill=%h pos=%0d / got wr=%0d addr=%0d ch=%h attr=%h scr=%0d",
                        " clr=%0d fill=%h pos=%0d"},
                       want.wr, want.addr, want.ch, want.attr, want.scroll, want.clr,
                       want.fill, want.cursor, got.wr, got.addr, got.ch, got.attr,
                       got.scroll, got.clr, got.fill, got.cursor);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1;
        console_step(chars_to_send.pop_front());
      end
    end
  end

  initial begin
    rst                  = 1;
    cfg_we               = 0;
    cfg_wdata            = 0;
    in_ch.valid          = 0;
    in_ch.action         = ACT_MARKUP;
    in_ch.char_code      = 0;
    in_ch.last_of_string = 0;
    out_ch.ready         = 0;
    bad_words            = 0;
    cycles               = 0;
    chars_queued         = 0;
    in_took              = 0;
    send_idle_pct        = 26;
    recv_idle_pct        = 57;
    color_dflt           = DEFAULT_COLOR_RESET;
    color_now            = DEFAULT_COLOR_RESET;
    con_col              = 0;
    con_row              = 0;
    tag_phase            = TAG_OUT;
    tag_close            = 0;
    tag_len              = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    push(ACT_MARKUP, "A", 0);
    push(ACT_MARKUP, CH_LT, 0);
    push(ACT_MARKUP, "r", 0);
    push(ACT_RAW, "x", 0);        // raw while a tag is open
    push(ACT_MARKUP, "e", 0);
    push(ACT_MARKUP, "d", 0);
    push(ACT_MARKUP, CH_GT, 0);
    push(ACT_MARKUP, 8'h00, 0);
    push(ACT_MARKUP, CH_LT, 0);
    push(ACT_MARKUP, CH_SLASH, 0);
    push(ACT_MARKUP, "q", 0);
    push(ACT_MARKUP, CH_GT, 0);   // back to reset default
    push(ACT_CLEAR, 8'hA5, 1);
    push(ACT_MARKUP, CH_BS, 0);   // backspace at top-left
    push(ACT_MARKUP, CH_NL, 0);
    push(ACT_RAW, CH_BS, 0);      // back to end of row 0
    push(ACT_RAW, 8'hFF, 1);      // wraps
    push(ACT_NONE, "Z", 1);
    push(ACT_MARKUP, CH_LT, 1);   // empty tag closed by end of string
    push(ACT_MARKUP, CH_LT, 0);
    push(ACT_MARKUP, "b", 0);
    push(ACT_MARKUP, "l", 0);
    push(ACT_MARKUP, "u", 0);
    push(ACT_MARKUP, "e", 1);
    push(ACT_RAW, CH_LT, 1);
    settle();

    write_default(8'h00);
    push(ACT_MARKUP, CH_LT, 0);
    push(ACT_MARKUP, CH_SLASH, 1);
    push(ACT_MARKUP, "k", 0);
    settle();

    write_default(8'hFF);
    fill_random(150);
    settle();

    send_idle_pct = 57;
    recv_idle_pct = 26;
    write_default(8'($urandom_range(1, 254)));
    fill_random(150);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_default(8'($urandom_range(255)));
    fill_random(150);
    settle();

    if (bad_words == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_if.sv
hdl/tcc_front.sv
hdl/tcc_queue.sv
hdl/tcc_back.sv
hdl/text_console_with_color_tags.sv
tb/sv/text_console_with_color_tags_test.sv
